/* hw/rtl/sensor_registry_log_framer_macros.svh */
// Assertion helpers for the checker file.
`ifndef SENSOR_REGISTRY_LOG_FRAMER_MACROS_SVH
`define SENSOR_REGISTRY_LOG_FRAMER_MACROS_SVH

// Checked out of reset only.
`define SRLF_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("srlf check failed");

// Checked on every edge, reset included.
`define SRLF_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("srlf reset check failed");

`endif

/* hw/rtl/srlf_pkg.sv */
package srlf_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    localparam logic [7:0]  FRAME_MARKER = 8'hAA;
    localparam logic [7:0]  FRAME_BASE   = 8'd4;
    localparam logic [31:0] FLOAT_ONE    = 32'h3F80_0000;
    localparam logic [31:0] FLOAT_ZERO   = 32'h0000_0000;

    typedef enum logic [1:0] {
        CK_HDR   = 2'd0,
        CK_STAMP = 2'd1,
        CK_REC   = 2'd2,
        CK_CSUM  = 2'd3
    } t_chunk_kind;

    typedef struct packed {
        logic        kind;
        logic [7:0]  sensor_id;
        logic [1:0]  value_type;
        logic [31:0] raw_value;
        logic [31:0] stamp;
    } t_item;

    typedef struct packed {
        logic        load_item;
        logic        idx_clr;
        logic        idx_inc;
        logic        mem_rd;
        logic        wr_update;
        logic        wr_append;
        logic        conv_start;
        logic        emit;
        t_chunk_kind emit_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic item_kind;
        logic idx_at_count;
        logic full;
        logic id_match;
        logic rd_is_int;
        logic conv_done;
        logic out_free;
    } t_dp_status;

endpackage

/* hw/rtl/srlf_if.sv */
interface srlf_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  sensor_id;
    logic [1:0]  value_type;
    logic [31:0] raw_value;
    logic [31:0] stamp;

    modport source (output valid, kind, sensor_id, value_type, raw_value, stamp,
                    input ready);
    modport sink   (input valid, kind, sensor_id, value_type, raw_value, stamp,
                    output ready);
endinterface

interface srlf_out_if;
    logic        valid;
    logic        ready;
    logic [39:0] chunk_data;
    logic [2:0]  chunk_bytes;
    logic [1:0]  chunk_kind;
    logic        last;

    modport source (output valid, chunk_data, chunk_bytes, chunk_kind, last,
                    input ready);
    modport sink   (input valid, chunk_data, chunk_bytes, chunk_kind, last,
                    output ready);
endinterface

/* hw/rtl/sensor_registry_log_framer.sv */
// Sensor registry and log framer. Set items (kind 0) look up the 8-bit id in a
// single-port registry of up to 32 entries, searched one entry at a time, and
// either replace the stored value or, if the registry is not full, append a
// new entry; a set item gives no beat. Log items (kind 1) emit a header beat,
// a timestamp beat, one five-byte record beat per entry and a checksum beat
// with last set. Integer entries go through a shared int-to-single converter
// whose normalizer shifts by 8 or 1 bit per cycle. The output register lets
// the next item be taken while the final beat still waits. Stalls on the
// chunk channel add cycles.
module sensor_registry_log_framer import srlf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srlf_in_if.sink    i_item,
    srlf_out_if.source o_chunk
);

    t_item      w_item;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_ready;

    assign w_item = '{
        kind:       i_item.kind,
        sensor_id:  i_item.sensor_id,
        value_type: i_item.value_type,
        raw_value:  i_item.raw_value,
        stamp:      i_item.stamp
    };
    assign i_item.ready = w_ready;

    srlf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    srlf_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_item),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_chunk  (o_chunk)
    );

endmodule

/* hw/rtl/srlf_i2f.sv */
// int32 to single precision, round to nearest even.
// Normalizes by 8 or 1 bit per cycle, then rounds in the ST_ROUND state.
module srlf_i2f import srlf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_value,
    output logic        o_done,
    output logic [31:0] o_result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NORM,
        ST_ROUND
    } t_state;

    t_state      r_state;
    logic        r_sign;
    logic [31:0] r_mag;
    logic [4:0]  r_sh;
    logic [31:0] r_result;
    logic        r_done;

    logic        w_round_up;
    logic [24:0] w_man;
    logic [7:0]  w_exp;

    always_comb begin
        // guard bit set and (sticky or odd mantissa)
        w_round_up = r_mag[7] && ((|r_mag[6:0]) || r_mag[8]);
        w_man      = {1'b0, r_mag[31:8]} + {24'd0, w_round_up};
        w_exp      = 8'd158 - {3'd0, r_sh};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_sign  <= i_value[31];
                        r_mag   <= i_value[31] ? (32'd0 - i_value) : i_value;
                        r_sh    <= 5'd0;
                        r_done  <= 1'b0;
                        r_state <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    if (r_mag == 32'd0) begin
                        r_result <= FLOAT_ZERO;
                        r_done   <= 1'b1;
                        r_state  <= ST_IDLE;
                    end else if (r_mag[31]) begin
                        r_state <= ST_ROUND;
                    end else if (r_mag[31:24] == 8'd0) begin
                        r_mag <= {r_mag[23:0], 8'd0};
                        r_sh  <= r_sh + 5'd8;
                    end else begin
                        r_mag <= {r_mag[30:0], 1'b0};
                        r_sh  <= r_sh + 5'd1;
                    end
                end
                ST_ROUND: begin
                    if (w_man[24]) begin
                        r_result <= {r_sign, w_exp + 8'd1, 23'd0};
                    end else begin
                        r_result <= {r_sign, w_exp, w_man[22:0]};
                    end
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* hw/rtl/srlf_dp.sv */
module srlf_dp import srlf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_item,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    srlf_out_if.source  o_chunk
);

    localparam logic [1:0] VT_FLOAT = 2'd0;
    localparam logic [1:0] VT_INT   = 2'd1;
    localparam logic [1:0] VT_BOOL  = 2'd2;

    typedef struct packed {
        logic [7:0]  id;
        logic [1:0]  vtype;
        logic [31:0] value;
    } t_entry;

    t_entry             r_mem [MAX_ENTRIES];
    t_entry             r_rd;
    t_item              r_item;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_count;
    logic [7:0]         r_sum;

    logic               r_out_valid;
    logic [39:0]        r_out_data;
    logic [2:0]         r_out_bytes;
    t_chunk_kind        r_out_kind;
    logic               r_out_last;

    logic               w_wr_en;
    logic [IDX_W-1:0]   w_wr_addr;
    t_entry             w_wr_data;
    logic [7:0]         w_len;
    logic [31:0]        w_rec_val;
    logic [39:0]        w_data;
    logic [2:0]         w_bytes;
    logic [7:0]         w_bsum;
    logic               w_out_free;
    logic               w_conv_done;
    logic [31:0]        w_conv_val;

    srlf_i2f u_i2f (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.conv_start),
        .i_value  (r_rd.value),
        .o_done   (w_conv_done),
        .o_result (w_conv_val)
    );

    // Update rewrites the entry read during the search with only a new value.
    always_comb begin
        w_wr_en = i_cmd.wr_update || i_cmd.wr_append;
        if (i_cmd.wr_append) begin
            w_wr_addr = r_count[IDX_W-1:0];
            w_wr_data = '{id: r_item.sensor_id, vtype: r_item.value_type,
                          value: r_item.raw_value};
        end else begin
            w_wr_addr = r_idx[IDX_W-1:0];
            w_wr_data = '{id: r_rd.id, vtype: r_rd.vtype, value: r_item.raw_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.mem_rd) begin
            r_rd <= r_mem[r_idx[IDX_W-1:0]];
        end
        if (i_cmd.load_item) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        w_len = FRAME_BASE + 8'({r_count, 2'b00}) + 8'(r_count);
        case (r_rd.vtype)
            VT_FLOAT: w_rec_val = r_rd.value;
            VT_INT:   w_rec_val = w_conv_val;
            VT_BOOL:  w_rec_val = (r_rd.value != 32'd0) ? FLOAT_ONE : FLOAT_ZERO;
            default:  w_rec_val = FLOAT_ZERO;
        endcase
        case (i_cmd.emit_kind)
            CK_HDR: begin
                w_data  = {24'd0, w_len, FRAME_MARKER};
                w_bytes = 3'd2;
            end
            CK_STAMP: begin
                w_data  = {8'd0, r_item.stamp};
                w_bytes = 3'd4;
            end
            CK_REC: begin
                w_data  = {w_rec_val, r_rd.id};
                w_bytes = 3'd5;
            end
            default: begin
                w_data  = {32'd0, r_sum};
                w_bytes = 3'd1;
            end
        endcase
        // unused bytes are zero, so all five can be summed
        w_bsum = w_data[7:0] + w_data[15:8] + w_data[23:16] + w_data[31:24]
               + w_data[39:32];
        w_out_free = !r_out_valid || o_chunk.ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_count     <= '0;
            r_sum       <= 8'd0;
        end else begin
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.wr_append) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_sum       <= (i_cmd.emit_kind == CK_HDR) ? w_bsum : r_sum + w_bsum;
            end else if (o_chunk.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data  <= w_data;
            r_out_bytes <= w_bytes;
            r_out_kind  <= i_cmd.emit_kind;
            r_out_last  <= (i_cmd.emit_kind == CK_CSUM);
        end
    end

    assign o_chunk.valid       = r_out_valid;
    assign o_chunk.chunk_data  = r_out_data;
    assign o_chunk.chunk_bytes = r_out_bytes;
    assign o_chunk.chunk_kind  = r_out_kind;
    assign o_chunk.last        = r_out_last;

    assign o_status = '{
        item_kind:    r_item.kind,
        idx_at_count: (r_idx == r_count),
        full:         (r_count == CNT_W'(MAX_ENTRIES)),
        id_match:     (r_rd.id == r_item.sensor_id),
        rd_is_int:    (r_rd.vtype == VT_INT),
        conv_done:    w_conv_done,
        out_free:     w_out_free
    };

endmodule

/* hw/rtl/srlf_ctrl.sv */
module srlf_ctrl import srlf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SET_RD,
        ST_SET_CMP,
        ST_LOG_HDR,
        ST_LOG_STAMP,
        ST_LOG_RD,
        ST_LOG_CONV,
        ST_LOG_WAIT,
        ST_LOG_REC,
        ST_LOG_CSUM
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    o_cmd.idx_clr   = 1'b1;
                    n_state         = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = i_status.item_kind ? ST_LOG_HDR : ST_SET_RD;
            end
            ST_SET_RD: begin
                if (i_status.idx_at_count) begin
                    o_cmd.wr_append = !i_status.full;
                    n_state         = ST_IDLE;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = ST_SET_CMP;
                end
            end
            ST_SET_CMP: begin
                if (i_status.id_match) begin
                    o_cmd.wr_update = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = ST_SET_RD;
                end
            end
            ST_LOG_HDR: begin
                o_cmd.emit_kind = CK_HDR;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_LOG_STAMP;
                end
            end
            ST_LOG_STAMP: begin
                o_cmd.emit_kind = CK_STAMP;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_LOG_RD;
                end
            end
            ST_LOG_RD: begin
                if (i_status.idx_at_count) begin
                    n_state = ST_LOG_CSUM;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = ST_LOG_CONV;
                end
            end
            ST_LOG_CONV: begin
                if (i_status.rd_is_int) begin
                    o_cmd.conv_start = 1'b1;
                    n_state          = ST_LOG_WAIT;
                end else begin
                    n_state = ST_LOG_REC;
                end
            end
            ST_LOG_WAIT: begin
                if (i_status.conv_done) begin
                    n_state = ST_LOG_REC;
                end
            end
            ST_LOG_REC: begin
                o_cmd.emit_kind = CK_REC;
                if (i_status.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                    n_state       = ST_LOG_RD;
                end
            end
            ST_LOG_CSUM: begin
                o_cmd.emit_kind = CK_CSUM;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/srlf_chk.sv */
`include "sensor_registry_log_framer_macros.svh"

module srlf_chk import srlf_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [39:0] i_chunk_data,
    input logic [2:0]  i_chunk_bytes,
    input logic [1:0]  i_chunk_kind,
    input logic        i_last
);

    // a stalled beat holds
    `SRLF_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_chunk_data) && $stable(i_chunk_kind))
    `SRLF_ASSERT(a_last_is_csum, i_out_valid |-> (i_last == (i_chunk_kind == CK_CSUM)))
    `SRLF_ASSERT(a_rec_bytes, i_out_valid && (i_chunk_kind == CK_REC) |-> (i_chunk_bytes == 3'd5))
    // the beat after a frame end opens a new frame
    `SRLF_ASSERT(a_frame_start, i_out_valid && i_out_ready && i_last |=> !i_out_valid || (i_chunk_kind == CK_HDR))
    `SRLF_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !i_out_valid)

endmodule

bind sensor_registry_log_framer srlf_chk u_srlf_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_chunk.valid),
    .i_out_ready   (o_chunk.ready),
    .i_chunk_data  (o_chunk.chunk_data),
    .i_chunk_bytes (o_chunk.chunk_bytes),
    .i_chunk_kind  (o_chunk.chunk_kind),
    .i_last        (o_chunk.last)
);

/* tb/sensor_registry_log_framer_test.sv */
module sensor_registry_log_framer_test;
    import srlf_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 160;
    localparam int QUIET_ITEMS  = 30;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PROBE_COUNT  = 21;

    typedef enum logic {
        ITEM_SET = 1'b0,
        ITEM_LOG = 1'b1
    } item_kind_e;

    typedef enum logic [1:0] {
        VT_FLOAT   = 2'd0,
        VT_INT     = 2'd1,
        VT_BOOL    = 2'd2,
        VT_UNKNOWN = 2'd3
    } value_type_e;

    typedef struct packed {
        logic [39:0] data;
        logic [2:0]  nbytes;
        t_chunk_kind kind;
        logic        last;
    } chunk_t;

    // typed: frame on an empty registry, checksum given in csum
    typedef struct packed {
        t_item      item;
        logic       typed;
        logic [7:0] csum;
    } probe_t;

    logic i_clk;
    logic i_rst_n;

    srlf_in_if  item_if ();
    srlf_out_if chunk_if ();

    sensor_registry_log_framer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_chunk (chunk_if)
    );

    // registry mirror
    logic [7:0]  reg_ids    [MAX_ENTRIES];
    logic [1:0]  reg_types  [MAX_ENTRIES];
    logic [31:0] reg_values [MAX_ENTRIES];
    int          reg_count;

    chunk_t chunks_due [$];
    int     fail_count;
    int     items_taken;
    int     cycle_count;
    bit     quiet;

    probe_t probes [PROBE_COUNT] = '{
        '{'{ITEM_LOG, 8'hFF, VT_UNKNOWN, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b1, 8'hAE},
        '{'{ITEM_LOG, 8'h00, VT_FLOAT,   32'h0000_0000, 32'hFFFF_FFFF}, 1'b1, 8'hAA},
        '{'{ITEM_SET, 8'h00, VT_FLOAT,   32'h3F80_0000, 32'hFFFF_FFFF}, 1'b0, 8'h00},
        '{'{ITEM_SET, 8'hFF, VT_INT,     32'h8000_0000, 32'h0000_0000}, 1'b0, 8'h00},
        '{'{ITEM_SET, 8'h01, VT_INT,     32'h7FFF_FFFF, 32'h0000_0000}, 1'b0, 8'h00},
        '{'{ITEM_SET, 8'h02, VT_INT,     32'h0000_0000, 32'h0000_0000}, 1'b0, 8'h00},
        '{'{ITEM_SET, 8'h03, VT_INT,     32'h0100_0001, 32'h0000_0000}, 1'b0, 8'h00},
        '{'{ITEM_SET, 8'h04, VT_INT,     32'h0100_0003, 32'h0000_0000}, 1'b0, 8'h00},
        '{'{ITEM_SET, 8'h05, VT_INT,     32'hFFFF_FFFF, 32'h0000_0000}, 1'b0, 8'h00},
        '{'{ITEM_SET, 8'h06, VT_BOOL,    32'h0000_0000, 32'h0000_0000}, 1'b0, 8'h00},
        '{'{ITEM_SET, 8'h07, VT_BOOL,    32'h8000_0000, 32'h0000_0000}, 1'b0, 8'h00},
        '{'{ITEM_SET, 8'h08, VT_UNKNOWN, 32'hDEAD_BEEF, 32'h0000_0000}, 1'b0, 8'h00},
        '{'{ITEM_SET, 8'h09, VT_FLOAT,   32'hFFFF_FFFF, 32'h0000_0000}, 1'b0, 8'h00},
        '{'{ITEM_SET, 8'h0A, VT_FLOAT,   32'h8000_0000, 32'h0000_0000}, 1'b0, 8'h00},
        '{'{ITEM_SET, 8'h0B, VT_INT,     32'h00FF_FFFF, 32'h0000_0000}, 1'b0, 8'h00},
        '{'{ITEM_SET, 8'h0C, VT_INT,     32'h7FFF_FFC0, 32'h0000_0000}, 1'b0, 8'h00},
        '{'{ITEM_LOG, 8'h5A, VT_BOOL,    32'h1234_5678, 32'h1234_5678}, 1'b0, 8'h00},
        // id already present: value replaced, stored type kept
        '{'{ITEM_SET, 8'hFF, VT_FLOAT,   32'h00FF_FFFF, 32'h0000_0000}, 1'b0, 8'h00},
        '{'{ITEM_SET, 8'h00, VT_BOOL,    32'h0000_0005, 32'h0000_0000}, 1'b0, 8'h00},
        '{'{ITEM_SET, 8'h0A, VT_UNKNOWN, 32'h4049_0FDB, 32'h0000_0000}, 1'b0, 8'h00},
        '{'{ITEM_LOG, 8'hA5, VT_INT,     32'hFFFF_FFFF, 32'h8000_0001}, 1'b0, 8'h00}
    };

    function automatic logic [31:0] int_to_f32(logic [31:0] bits);
        logic        sign;
        logic [31:0] mag;
        logic [31:0] man;
        logic [31:0] rem;
        logic [31:0] half;
        logic [7:0]  expo;
        int          p;
        int          sh;
        sign = bits[31];
        mag  = sign ? -bits : bits;
        if (mag == 32'd0) begin
            return 32'd0;
        end
        p = 31;
        while (!mag[p]) begin
            p--;
        end
        expo = 8'(127 + p);
        if (p <= 23) begin
            man = mag << (23 - p);
        end else begin
            sh   = p - 23;
            rem  = mag & ((32'd1 << sh) - 32'd1);
            half = 32'd1 << (sh - 1);
            man  = mag >> sh;
            // round to nearest, ties to even
            if (rem > half || (rem == half && man[0])) begin
                man++;
            end
            if (man == 32'h0100_0000) begin
                man = man >> 1;
                expo++;
            end
        end
        return {sign, expo, man[22:0]};
    endfunction

    function automatic logic [31:0] entry_f32(int idx);
        case (value_type_e'(reg_types[idx]))
            VT_FLOAT: return reg_values[idx];
            VT_INT:   return int_to_f32(reg_values[idx]);
            VT_BOOL:  return (reg_values[idx] != 32'd0) ? FLOAT_ONE : FLOAT_ZERO;
            default:  return FLOAT_ZERO;
        endcase
    endfunction

    function automatic logic [7:0] byte_total(logic [39:0] data, int nbytes);
        logic [7:0] s;
        s = 8'd0;
        for (int k = 0; k < nbytes; k++) begin
            s += data[8*k +: 8];
        end
        return s;
    endfunction

    function automatic void push_chunk(logic [39:0] data, int nbytes, t_chunk_kind kind,
                                       logic last);
        chunk_t c;
        c.data   = data;
        c.nbytes = 3'(nbytes);
        c.kind   = kind;
        c.last   = last;
        chunks_due.push_back(c);
    endfunction

    function automatic void registry_step(t_item it);
        logic [39:0] d;
        logic [7:0]  len;
        logic [7:0]  sum;
        bit          hit;
        hit = 1'b0;
        if (it.kind == ITEM_SET) begin
            for (int i = 0; i < reg_count; i++) begin
                if (!hit && reg_ids[i] == it.sensor_id) begin
                    reg_values[i] = it.raw_value;
                    hit = 1'b1;
                end
            end
            if (!hit && reg_count < MAX_ENTRIES) begin
                reg_ids[reg_count]    = it.sensor_id;
                reg_types[reg_count]  = it.value_type;
                reg_values[reg_count] = it.raw_value;
                reg_count++;
            end
        end else begin
            len = 8'(4 + 5 * reg_count);
            d   = {24'd0, len, FRAME_MARKER};
            sum = byte_total(d, 2);
            push_chunk(d, 2, CK_HDR, 1'b0);
            d   = {8'd0, it.stamp};
            sum += byte_total(d, 4);
            push_chunk(d, 4, CK_STAMP, 1'b0);
            for (int i = 0; i < reg_count; i++) begin
                d = {entry_f32(i), reg_ids[i]};
                sum += byte_total(d, 5);
                push_chunk(d, 5, CK_REC, 1'b0);
            end
            push_chunk({32'd0, sum}, 1, CK_CSUM, 1'b1);
        end
    endfunction

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_item(t_item it, logic typed, logic [7:0] csum);
        item_if.valid      <= 1'b1;
        item_if.kind       <= it.kind;
        item_if.sensor_id  <= it.sensor_id;
        item_if.value_type <= it.value_type;
        item_if.raw_value  <= it.raw_value;
        item_if.stamp      <= it.stamp;
        @(posedge i_clk);
        while (!item_if.ready) begin
            @(posedge i_clk);
        end
        items_taken++;
        if (typed) begin
            push_chunk({24'd0, FRAME_BASE, FRAME_MARKER}, 2, CK_HDR, 1'b0);
            push_chunk({8'd0, it.stamp}, 4, CK_STAMP, 1'b0);
            push_chunk({32'd0, csum}, 1, CK_CSUM, 1'b1);
        end else begin
            registry_step(it);
        end
        @(negedge i_clk);
    endtask

    task automatic sender_pause();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("sensor_registry_log_framer regression: fail");
        $finish;
    end

    // receiver: random stall bursts, one long hold-off to back up the input
    int  stall_left;
    bit  hold_done;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            chunk_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            chunk_if.ready <= 1'b0;
            stall_left--;
        end else if (!hold_done && items_taken >= HOLD_AT) begin
            hold_done = 1'b1;
            stall_left = HOLD_CYCLES - 1;
            chunk_if.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            chunk_if.ready <= 1'b0;
        end else begin
            chunk_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        chunk_t want;
        if (i_rst_n && chunk_if.valid && chunk_if.ready) begin
            if (chunks_due.size() == 0) begin
                $error("chunk beat with none due: data %h", chunk_if.chunk_data);
                fail_count++;
            end else begin
                want = chunks_due.pop_front();
                if (chunk_if.chunk_data !== want.data) begin
                    $error("chunk_data: expected %h, actual %h", want.data,
                           chunk_if.chunk_data);
                    fail_count++;
                end
                if (chunk_if.chunk_bytes !== want.nbytes) begin
                    $error("chunk_bytes: expected %0d, actual %0d", want.nbytes,
                           chunk_if.chunk_bytes);
                    fail_count++;
                end
                if (chunk_if.chunk_kind !== want.kind) begin
                    $error("chunk_kind: expected %0d, actual %0d", want.kind,
                           chunk_if.chunk_kind);
                    fail_count++;
                end
                if (chunk_if.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, chunk_if.last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_item       it;
        logic [31:0] raw;
        fail_count  = 0;
        items_taken = 0;
        reg_count   = 0;
        quiet       = 1'b0;
        stall_left  = 0;
        hold_done   = 1'b0;
        i_rst_n            = 1'b0;
        item_if.valid      = 1'b0;
        item_if.kind       = ITEM_SET;
        item_if.sensor_id  = 8'd0;
        item_if.value_type = VT_FLOAT;
        item_if.raw_value  = 32'd0;
        item_if.stamp      = 32'd0;
        chunk_if.ready     = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < PROBE_COUNT; n++) begin
            send_item(probes[n].item, probes[n].typed, probes[n].csum);
            sender_pause();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            it.kind = ($urandom_range(0, 3) == 0) ? ITEM_LOG : ITEM_SET;
            // often revisit known ids so updates and a full registry both occur
            if (reg_count > 0 && $urandom_range(0, 9) < 4) begin
                it.sensor_id = reg_ids[$urandom_range(0, reg_count - 1)];
            end else begin
                it.sensor_id = 8'($urandom_range(0, 255));
            end
            it.value_type = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: raw = $urandom;
                1: raw = 32'($urandom_range(0, 200)) - 32'd100;
                2: begin
                    raw = $urandom >> $urandom_range(0, 31);
                    if ($urandom_range(0, 1) == 1) begin
                        raw = -raw;
                    end
                end
                default: begin
                    case ($urandom_range(0, 4))
                        0: raw = 32'h0000_0000;
                        1: raw = 32'h0000_0001;
                        2: raw = 32'h8000_0000;
                        3: raw = 32'h7FFF_FFFF;
                        default: raw = 32'hFFFF_FFFF;
                    endcase
                end
            endcase
            it.raw_value = raw;
            it.stamp     = $urandom;
            send_item(it, 1'b0, 8'd0);
            sender_pause();
        end
        item_if.valid <= 1'b0;

        while (chunks_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("sensor_registry_log_framer regression: pass");
        end else begin
            $display("sensor_registry_log_framer regression: fail");
        end
        $finish;
    end

endmodule
